@@ rtl/core/flpw_pkg.sv @@
// Shared types and constants of the four-level page walker.
`timescale 1ns / 1ps

package flpw_pkg;

    localparam int unsigned LA_W    = 48;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned FRAME_W = 40;
    localparam int unsigned DATA_W  = 112;

    localparam logic MODE_REQ  = 1'b0;
    localparam logic MODE_RESP = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_PS      = 7;

    // Level of the entry awaited.
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    typedef enum logic [1:0] {
        MAP_4K = 2'd0,
        MAP_2M = 2'd1,
        MAP_1G = 2'd2
    } map_size_t;

    typedef struct packed {
        logic                  is_req;
        logic [LA_W-1:0]       linear;
        logic                  present;
        logic                  large_page;
        logic [FRAME_W-1:0]    frame;
    } walk_item_t;

    typedef struct packed {
        logic                  kind;
        logic [PA_W-1:0]       read_address;
        logic [PA_W-1:0]       physical_address;
        logic                  fault;
        map_size_t             size;
    } walk_result_t;

endpackage

@@ rtl/core/flpw_front.sv @@
// Input stage: accept and classify requests and entry responses.
`timescale 1ns / 1ps

module flpw_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_mode,
    input  logic [flpw_pkg::LA_W-1:0]           in_linear,
    input  logic [flpw_pkg::ENTRY_W-1:0]        in_entry,
    output logic                                q_valid,
    input  logic                                q_ready,
    output flpw_pkg::walk_item_t                q_item
);

    logic                 valid_reg;
    logic                 valid_next;
    flpw_pkg::walk_item_t item_reg;
    flpw_pkg::walk_item_t item_next;

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb begin
        item_next.is_req     = (in_mode == flpw_pkg::MODE_REQ);
        item_next.linear     = in_linear;
        item_next.present    = in_entry[flpw_pkg::BIT_PRESENT];
        item_next.large_page = in_entry[flpw_pkg::BIT_PS];
        item_next.frame      = in_entry[51:12];
    end

    always_comb begin
        valid_next = valid_reg && !q_ready;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/flpw_queue.sv @@
// Small queue of classified transactions between front and back.
`timescale 1ns / 1ps

module flpw_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  flpw_pkg::walk_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output flpw_pkg::walk_item_t  out_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    flpw_pkg::walk_item_t mem [DEPTH];
    logic [PTR_W:0]       wr_ptr_reg;
    logic [PTR_W:0]       wr_ptr_next;
    logic [PTR_W:0]       rd_ptr_reg;
    logic [PTR_W:0]       rd_ptr_next;
    logic                 full;
    logic                 empty;
    logic                 push;
    logic                 pop;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);

    assign in_ready  = !full;
    assign out_valid = !empty;
    assign out_item  = mem[rd_ptr_reg[PTR_W-1:0]];
    assign push      = in_valid && !full;
    assign pop       = out_ready && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg[PTR_W-1:0]] <= in_item;
        end
    end

endmodule

@@ rtl/core/flpw_back.sv @@
// Walk engine: level tracking, address forming and result register.
`timescale 1ns / 1ps

module flpw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [flpw_pkg::PA_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  flpw_pkg::walk_item_t          in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output flpw_pkg::walk_result_t        out_result
);

    logic [flpw_pkg::PA_W-1:0]  base_reg;
    logic                       busy_reg;
    logic                       busy_next;
    logic [1:0]                 level_reg;
    logic [1:0]                 level_next;
    logic [flpw_pkg::LA_W-1:0]  saved_reg;
    logic [flpw_pkg::LA_W-1:0]  saved_next;
    logic                       valid_reg;
    logic                       valid_next;
    flpw_pkg::walk_result_t     result_reg;
    flpw_pkg::walk_result_t     result_next;
    logic                       produce;
    logic                       pop;

    assign in_ready   = !valid_reg || out_ready;
    assign pop        = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        busy_next                    = busy_reg;
        level_next                   = level_reg;
        saved_next                   = saved_reg;
        produce                      = 1'b0;
        result_next.kind             = flpw_pkg::KIND_READ;
        result_next.read_address     = '0;
        result_next.physical_address = '0;
        result_next.fault            = 1'b0;
        result_next.size             = flpw_pkg::MAP_4K;

        if (in_item.is_req) begin
            produce                  = 1'b1;
            busy_next                = 1'b1;
            level_next               = flpw_pkg::LVL_PML4;
            saved_next               = in_item.linear;
            result_next.read_address = {base_reg[51:12], in_item.linear[47:39], 3'b000};
        end else if (busy_reg) begin
            produce = 1'b1;
            if (!in_item.present) begin
                busy_next         = 1'b0;
                level_next        = flpw_pkg::LVL_PT;
                result_next.kind  = flpw_pkg::KIND_DONE;
                result_next.fault = 1'b1;
            end else begin
                unique case (level_reg)
                    flpw_pkg::LVL_PML4: begin
                        level_next               = flpw_pkg::LVL_PDPT;
                        result_next.read_address = {in_item.frame, saved_reg[38:30], 3'b000};
                    end
                    flpw_pkg::LVL_PDPT: begin
                        if (in_item.large_page) begin
                            busy_next                    = 1'b0;
                            level_next                   = flpw_pkg::LVL_PT;
                            result_next.kind             = flpw_pkg::KIND_DONE;
                            result_next.size             = flpw_pkg::MAP_1G;
                            result_next.physical_address = {in_item.frame[39:18],
                                                            saved_reg[29:0]};
                        end else begin
                            level_next               = flpw_pkg::LVL_PD;
                            result_next.read_address = {in_item.frame, saved_reg[29:21],
                                                        3'b000};
                        end
                    end
                    flpw_pkg::LVL_PD: begin
                        if (in_item.large_page) begin
                            busy_next                    = 1'b0;
                            level_next                   = flpw_pkg::LVL_PT;
                            result_next.kind             = flpw_pkg::KIND_DONE;
                            result_next.size             = flpw_pkg::MAP_2M;
                            result_next.physical_address = {in_item.frame[39:9],
                                                            saved_reg[20:0]};
                        end else begin
                            level_next               = flpw_pkg::LVL_PT;
                            result_next.read_address = {in_item.frame, saved_reg[20:12],
                                                        3'b000};
                        end
                    end
                    flpw_pkg::LVL_PT: begin
                        busy_next                    = 1'b0;
                        result_next.kind             = flpw_pkg::KIND_DONE;
                        result_next.physical_address = {in_item.frame, saved_reg[11:0]};
                    end
                endcase
            end
        end
    end

    always_comb begin
        valid_next = valid_reg && !out_ready;
        if (pop && produce) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            busy_reg  <= 1'b0;
            level_reg <= flpw_pkg::LVL_PT;
            saved_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (pop) begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                saved_reg <= saved_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && produce) begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/core/four_level_page_walker.sv @@
// Top level of the four-level page walker.
//
//  port     | dir | tuser       | tdata fields, low bit first
//  ---------+-----+-------------+-----------------------------------------------------
//  s_axis   | in  | mode        | vaddr, entry_data
//  m_axis   | out | result_kind | read_address, physical_address, fault, mapping_size
//  cfg      | in  | -           | page_table_base (write enable and data)
//
// One transaction per cycle each way while m_axis is ready and the queue is not full;
// a response with no walk in progress yields no result. A result passes the input
// register, the queue and the result register; the walk state updates once per item.
// Reset empties the queue, clears the walk state and the table base; no clearing pass.
// A stalled m_axis holds its result while the queue keeps taking input until full.
`timescale 1ns / 1ps

module four_level_page_walker #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [flpw_pkg::PA_W-1:0]          cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vaddr [47:0], entry_data [111:48]
    input  logic [flpw_pkg::DATA_W-1:0]        s_axis_tdata,
    // mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_address [51:0], physical_address [103:52], fault [104],
    // mapping_size [106:105], zero [111:107]
    output logic [flpw_pkg::DATA_W-1:0]        m_axis_tdata,
    // result_kind
    output logic                               m_axis_tuser
);

    logic                   fq_valid;
    logic                   fq_ready;
    flpw_pkg::walk_item_t   fq_item;
    logic                   qb_valid;
    logic                   qb_ready;
    flpw_pkg::walk_item_t   qb_item;
    flpw_pkg::walk_result_t result;

    flpw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_linear (s_axis_tdata[47:0]),
        .in_entry  (s_axis_tdata[111:48]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    flpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    flpw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {5'b00000, result.size, result.fault,
                           result.physical_address, result.read_address};

endmodule

@@ rtl/core/flpw_checker.sv @@
// Port-level checks of the page walker, bound to the top level.
`timescale 1ns / 1ps

module flpw_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [flpw_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic                         m_axis_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == flpw_pkg::KIND_READ) |->
            (m_axis_tdata[111:52] == '0) && (m_axis_tdata[2:0] == 3'b000))
        else $error("read request carries completion fields");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == flpw_pkg::KIND_DONE) |->
            (m_axis_tdata[51:0] == '0))
        else $error("completion carries a read address");

    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[104] |->
            (m_axis_tdata[103:52] == '0) && (m_axis_tdata[106:105] == 2'b00))
        else $error("fault carries a translation");

    a_size_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[106:105] != 2'b11)
                          && (m_axis_tdata[111:107] == '0))
        else $error("bad mapping size or pad");

endmodule

bind four_level_page_walker flpw_checker u_flpw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb.sv @@
// Self-checking testbench for the four-level page walker: directed table, then random walks.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic                   mode;
        logic [47:0]            la;
        logic [63:0]            ent;
        bit                     typed;
        bit                     yields;
        flpw_pkg::walk_result_t res;
    } stim_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [flpw_pkg::PA_W-1:0]     cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [flpw_pkg::DATA_W-1:0]   s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [flpw_pkg::DATA_W-1:0]   m_axis_tdata;
    logic                          m_axis_tuser;

    flpw_pkg::walk_result_t        pending_results[$];
    stim_row_t                     dir_rows[$];
    int                            errors = 0;
    int                            items_done = 0;
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    int                            rx_hold = 0;

    logic [flpw_pkg::PA_W-1:0]     table_base = '0;
    bit                            walk_busy = 1'b0;
    logic [1:0]                    walk_lvl = flpw_pkg::LVL_PT;
    logic [flpw_pkg::LA_W-1:0]     walk_la = '0;

    four_level_page_walker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [flpw_pkg::PA_W-1:0] entry_addr(
            input logic [flpw_pkg::PA_W-1:0] tbl, input logic [1:0] lvl);
        logic [47:0] sh;
        sh = walk_la >> (12 + 9 * lvl);
        return {tbl[51:12], 12'h000} + {40'b0, sh[8:0], 3'b000};
    endfunction

    function automatic void translate_step(input logic mode, input logic [47:0] la,
                                           input logic [63:0] ent, output bit yields,
                                           output flpw_pkg::walk_result_t r);
        r = '0;
        yields = 1'b1;
        if (mode == flpw_pkg::MODE_REQ) begin
            walk_la = la;
            walk_busy = 1'b1;
            walk_lvl = flpw_pkg::LVL_PML4;
            r.kind = flpw_pkg::KIND_READ;
            r.read_address = entry_addr(table_base, flpw_pkg::LVL_PML4);
        end else if (!walk_busy) begin
            yields = 1'b0;
        end else if (!ent[flpw_pkg::BIT_PRESENT]) begin
            walk_busy = 1'b0;
            walk_lvl = flpw_pkg::LVL_PT;
            r.kind = flpw_pkg::KIND_DONE;
            r.fault = 1'b1;
        end else if (walk_lvl == flpw_pkg::LVL_PDPT && ent[flpw_pkg::BIT_PS]) begin
            walk_busy = 1'b0;
            walk_lvl = flpw_pkg::LVL_PT;
            r.kind = flpw_pkg::KIND_DONE;
            r.physical_address = {ent[51:30], walk_la[29:0]};
            r.size = flpw_pkg::MAP_1G;
        end else if (walk_lvl == flpw_pkg::LVL_PD && ent[flpw_pkg::BIT_PS]) begin
            walk_busy = 1'b0;
            walk_lvl = flpw_pkg::LVL_PT;
            r.kind = flpw_pkg::KIND_DONE;
            r.physical_address = {ent[51:21], walk_la[20:0]};
            r.size = flpw_pkg::MAP_2M;
        end else if (walk_lvl == flpw_pkg::LVL_PT) begin
            walk_busy = 1'b0;
            r.kind = flpw_pkg::KIND_DONE;
            r.physical_address = {ent[51:12], walk_la[11:0]};
            r.size = flpw_pkg::MAP_4K;
        end else begin
            walk_lvl = walk_lvl - 2'd1;
            r.kind = flpw_pkg::KIND_READ;
            r.read_address = entry_addr(ent[51:0], walk_lvl);
        end
    endfunction

    function automatic flpw_pkg::walk_result_t mk_res(
            input logic kind, input logic [flpw_pkg::PA_W-1:0] rd,
            input logic [flpw_pkg::PA_W-1:0] pa, input logic flt,
            input flpw_pkg::map_size_t sz);
        flpw_pkg::walk_result_t r;
        r.kind = kind;
        r.read_address = rd;
        r.physical_address = pa;
        r.fault = flt;
        r.size = sz;
        return r;
    endfunction

    function automatic void add_row(input logic mode, input logic [47:0] la,
                                    input logic [63:0] ent, input bit typed,
                                    input bit yields, input flpw_pkg::walk_result_t res);
        stim_row_t row;
        row.mode = mode;
        row.la = la;
        row.ent = ent;
        row.typed = typed;
        row.yields = yields;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    task automatic send_txn(input logic mode, input logic [47:0] la, input logic [63:0] ent,
                            input bit typed, input bit typed_yields,
                            input flpw_pkg::walk_result_t typed_res);
        bit                     yields;
        flpw_pkg::walk_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {ent, la};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        translate_step(mode, la, ent, yields, r);
        if (typed) begin
            if (typed_yields) pending_results.push_back(typed_res);
        end else if (yields) begin
            pending_results.push_back(r);
        end
        if (yields) items_done++;
        @(negedge aclk);
    endtask

    task automatic set_table_base(input logic [flpw_pkg::PA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        table_base = value;
    endtask

    task automatic run_random(input int target);
        logic [63:0] ent;
        int          steps;
        items_done = 0;
        while (items_done < target) begin
            if ($urandom_range(99) < 6) begin
                send_txn(flpw_pkg::MODE_RESP, 48'({$urandom, $urandom}),
                         {$urandom, $urandom}, 1'b0, 1'b0, '0);
            end else begin
                send_txn(flpw_pkg::MODE_REQ, 48'({$urandom, $urandom}),
                         {$urandom, $urandom}, 1'b0, 1'b0, '0);
                steps = 0;
                while (walk_busy && steps < 4 && $urandom_range(99) >= 5) begin
                    ent = {$urandom, $urandom};
                    ent[flpw_pkg::BIT_PRESENT] = ($urandom_range(99) < 92);
                    ent[flpw_pkg::BIT_PS] = ($urandom_range(99) < 35);
                    send_txn(flpw_pkg::MODE_RESP, 48'({$urandom, $urandom}), ent,
                             1'b0, 1'b0, '0);
                    steps++;
                end
            end
        end
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        flpw_pkg::walk_result_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation: kind %0d tdata %h",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $error("result_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[51:0] !== e.read_address) begin
                    $error("read_address: expected %h, got %h",
                           e.read_address, m_axis_tdata[51:0]);
                    errors++;
                end
                if (m_axis_tdata[103:52] !== e.physical_address) begin
                    $error("physical_address: expected %h, got %h",
                           e.physical_address, m_axis_tdata[103:52]);
                    errors++;
                end
                if (m_axis_tdata[104] !== e.fault) begin
                    $error("fault: expected %0d, got %0d", e.fault, m_axis_tdata[104]);
                    errors++;
                end
                if (m_axis_tdata[106:105] !== e.size) begin
                    $error("mapping_size: expected %0d, got %0d",
                           e.size, m_axis_tdata[106:105]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int drain;
        add_row(flpw_pkg::MODE_RESP, '1, '1, 1'b1, 1'b0, '0);
        add_row(flpw_pkg::MODE_REQ, '0, '0, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, '0, '0, 1'b0, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, '0, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_DONE, '0, '0, 1'b1, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_REQ, '1, '0, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hFF8, '0, 1'b0, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, '1, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0, 1'b0,
                       flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, '1, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_DONE, '0, '1, 1'b0, flpw_pkg::MAP_1G));
        add_row(flpw_pkg::MODE_REQ, '1, '0, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hFF8, '0, 1'b0, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0, 1'b0,
                       flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0, 1'b0,
                       flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_READ, 52'hF_FFFF_FFFF_FFF8, '0, 1'b0,
                       flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, '1, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_DONE, '0, '1, 1'b0, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_RESP, '0, '1, 1'b1, 1'b0, '0);
        add_row(flpw_pkg::MODE_REQ, 48'h8040_2010_0ABC, '0, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h8000_0001_2345_6081, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h0000_000A_BCDE_F063, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h0000_0007_FFE0_00E7, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_REQ, 48'h7FFF_C000_1234, '0, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h0000_0000_0010_0003, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_REQ, 48'h0000_4020_1FFF, '0, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h0000_0000_0020_0003, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1,
                mk_res(flpw_pkg::KIND_DONE, '0, '0, 1'b1, flpw_pkg::MAP_4K));
        add_row(flpw_pkg::MODE_REQ, 48'h1234_5678_9ABC, '0, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h1, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'h3, 1'b0, 1'b0, '0);
        add_row(flpw_pkg::MODE_RESP, '0, 64'hFFF0_0000_0000_0081, 1'b0, 1'b0, '0);

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_txn(dir_rows[i].mode, dir_rows[i].la, dir_rows[i].ent,
                     dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].res);

        set_table_base('1);
        rx_hold = 80;
        run_random(150);

        set_table_base('0);
        send_idle_pct = 84;
        run_random(150);

        set_table_base(52'({$urandom, $urandom}));
        send_idle_pct = 0;
        stall_pct = 84;
        run_random(150);

        set_table_base(52'({$urandom, $urandom}));
        send_idle_pct = 20;
        stall_pct = 20;
        run_random(150);

        set_table_base(52'h0_0000_0000_1FFF);
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(150);

        set_table_base(52'({$urandom, $urandom}));
        send_idle_pct = 20;
        stall_pct = 20;
        run_random(150);

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 5000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (10) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/flpw_pkg.sv
rtl/core/flpw_front.sv
rtl/core/flpw_queue.sv
rtl/core/flpw_back.sv
rtl/core/four_level_page_walker.sv
rtl/core/flpw_checker.sv
bench/tb.sv
